>>> sv/assert_macros.svh
// Assertion macros shared by the coefficient generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked at every clock edge outside reset.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> sv/bhpc_pkg.sv
// Shared constants and tables for the high-pass biquad coefficient generator.
package bhpc_pkg;
  localparam int ANG_W = 34;
  localparam int XY_W = 34;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [XY_W-1:0] ONE_Q30 = 34'sd1073741824;

  function automatic logic signed [ANG_W-1:0] atan_turn(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0: v = 34'sd536870912;
      5'd1: v = 34'sd316933406;
      5'd2: v = 34'sd167458907;
      5'd3: v = 34'sd85004756;
      5'd4: v = 34'sd42667331;
      5'd5: v = 34'sd21354466;
      5'd6: v = 34'sd10679838;
      5'd7: v = 34'sd5340245;
      5'd8: v = 34'sd2670163;
      5'd9: v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd41;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      5'd28: v = 34'sd3;
      5'd29: v = 34'sd1;
      5'd30: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

>>> sv/bhpc_cordic_stage.sv
// One registered CORDIC rotation step.
module bhpc_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic vld_i,
  input  logic signed [bhpc_pkg::XY_W-1:0] x_i,
  input  logic signed [bhpc_pkg::XY_W-1:0] y_i,
  input  logic signed [bhpc_pkg::ANG_W-1:0] z_i,
  input  logic [15:0] q_i,
  output logic vld_o,
  output logic signed [bhpc_pkg::XY_W-1:0] x_o,
  output logic signed [bhpc_pkg::XY_W-1:0] y_o,
  output logic signed [bhpc_pkg::ANG_W-1:0] z_o,
  output logic [15:0] q_o
);
  import bhpc_pkg::*;
  logic signed [XY_W-1:0] xs, ys;
  logic signed [ANG_W-1:0] at;
  logic vld_r;
  logic signed [XY_W-1:0] x_r, y_r;
  logic signed [ANG_W-1:0] z_r;
  logic [15:0] q_r;

  assign xs = x_i >>> STEP;
  assign ys = y_i >>> STEP;
  assign at = atan_turn(5'(STEP));

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_i;
  end

  always_ff @(posedge clk) begin
    q_r <= q_i;
    if (!z_i[ANG_W-1]) begin
      x_r <= x_i - ys;
      y_r <= y_i + xs;
      z_r <= z_i - at;
    end else begin
      x_r <= x_i + ys;
      y_r <= y_i - xs;
      z_r <= z_i + at;
    end
  end

  assign vld_o = vld_r;
  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
  assign q_o = q_r;
endmodule

>>> sv/bhpc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, rounded half up.
module bhpc_divider #(
  parameter int NUM_W = 62,
  parameter int DEN_W = 32,
  parameter int TAG_W = 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic vld_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic vld_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [TAG_W-1:0] tag_o
);
  // Remainder gets one spare bit so a shifted remainder never overflows.
  localparam int REM_W = DEN_W + 1;
  logic vld_r [NUM_W+1];
  logic [NUM_W-1:0] num_r [NUM_W+1];
  logic [NUM_W-1:0] quo_r [NUM_W+1];
  logic [REM_W-1:0] rem_r [NUM_W+1];
  logic [DEN_W-1:0] den_r [NUM_W+1];
  logic [TAG_W-1:0] tag_r [NUM_W+1];

  // Rounding: add den/2 to the numerator before dividing.
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else vld_r[0] <= vld_i;
    num_r[0] <= num_i + NUM_W'(den_i >> 1);
    quo_r[0] <= '0;
    rem_r[0] <= '0;
    den_r[0] <= den_i;
    tag_r[0] <= tag_i;
  end

  for (genvar g = 0; g < NUM_W; g++) begin : g_st
    logic [REM_W:0] sh;
    logic [REM_W:0] df;
    assign sh = {rem_r[g], num_r[g][NUM_W-1-g]};
    assign df = sh - {2'b00, den_r[g]};
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[g+1] <= 1'b0;
      else vld_r[g+1] <= vld_r[g];
      num_r[g+1] <= num_r[g];
      den_r[g+1] <= den_r[g];
      tag_r[g+1] <= tag_r[g];
      quo_r[g+1] <= {quo_r[g][NUM_W-2:0], ~df[REM_W]};
      rem_r[g+1] <= df[REM_W] ? sh[REM_W-1:0] : df[REM_W-1:0];
    end
  end

  assign vld_o = vld_r[NUM_W];
  assign quo_o = quo_r[NUM_W];
  assign tag_o = tag_r[NUM_W];
endmodule

>>> sv/biquad_highpass_coefficients_core.sv
// High-pass biquad coefficient generator: CORDIC, alpha and ratio pipelines.
// A new request is taken every cycle (busy is always low) and its result appears
// on the out_ ports with out_valid high after it has passed the CORDIC stages,
// the clamp register, the bit-per-stage alpha divider, the numerator register,
// the bit-per-stage coefficient dividers and the output register.
// The receiver cannot stall; results are delivered in request order.
`include "assert_macros.svh"
module biquad_highpass_coefficients_core #(
  parameter int COEF_WIDTH = 32,
  parameter int CORDIC_STEPS = 18
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [14:0] in_cutoff_norm,
  input  logic [15:0] in_quality,
  output logic out_valid,
  output logic signed [31:0] out_ff0,
  output logic signed [31:0] out_ff1,
  output logic signed [31:0] out_ff2,
  output logic signed [31:0] out_fb1,
  output logic signed [31:0] out_fb2,
  output logic out_bad_q
);
  import bhpc_pkg::*;
  localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  // CORDIC chain.
  logic cv [NSTEP+1];
  logic signed [XY_W-1:0] cx [NSTEP+1];
  logic signed [XY_W-1:0] cy [NSTEP+1];
  logic signed [ANG_W-1:0] cz [NSTEP+1];
  logic [15:0] cq [NSTEP+1];
  logic acc;

  assign busy = 1'b0;
  assign acc = start & ~busy;
  assign cv[0] = acc;
  assign cx[0] = CORDIC_GAIN;
  assign cy[0] = '0;
  assign cz[0] = {3'b000, in_cutoff_norm, 16'h0000} - {4'b0001, 30'd0};
  assign cq[0] = in_quality;

  for (genvar g = 0; g < NSTEP; g++) begin : g_cor
    bhpc_cordic_stage #(.STEP(g)) u_st (
      .clk(clk), .rst_n(rst_n), .vld_i(cv[g]), .x_i(cx[g]), .y_i(cy[g]),
      .z_i(cz[g]), .q_i(cq[g]), .vld_o(cv[g+1]), .x_o(cx[g+1]),
      .y_o(cy[g+1]), .z_o(cz[g+1]), .q_o(cq[g+1])
    );
  end

  // Clamp sin and cos and register.
  logic cl_v_r;
  logic [30:0] sn_r;
  logic signed [31:0] cs_r;
  logic [15:0] q1_r;
  logic signed [XY_W-1:0] cs_nxt;
  always_comb begin
    cs_nxt = -cy[NSTEP];
    if (cs_nxt > ONE_Q30) cs_nxt = ONE_Q30;
    if (cs_nxt < -ONE_Q30) cs_nxt = -ONE_Q30;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) cl_v_r <= 1'b0;
    else cl_v_r <= cv[NSTEP];
    q1_r <= cq[NSTEP];
    cs_r <= 32'(cs_nxt);
    if (cx[NSTEP] < 0) sn_r <= '0;
    else if (cx[NSTEP] > 34'sh7FFFFFFF) sn_r <= 31'h7FFFFFFF;
    else sn_r <= 31'(cx[NSTEP]);
  end

  // alpha = round(sin*128 / q). Zero quality is passed with a dummy divisor.
  localparam int TG1 = 32 + 1;
  logic a_v;
  logic [37:0] a_quo;
  logic [TG1-1:0] a_tag;
  bhpc_divider #(.NUM_W(38), .DEN_W(16), .TAG_W(TG1)) u_alpha (
    .clk(clk), .rst_n(rst_n), .vld_i(cl_v_r), .num_i({sn_r, 7'd0}),
    .den_i((q1_r == 16'd0) ? 16'd1 : q1_r),
    .tag_i({q1_r == 16'd0, cs_r}), .vld_o(a_v), .quo_o(a_quo), .tag_o(a_tag)
  );

  // Form numerators and denominator.
  logic n_v_r;
  logic [38:0] den_r;
  logic [61:0] n_ff0_r, n_ff1_r, n_fb1_r, n_fb2_r;
  logic [1:0] n_tag_r;
  logic [31:0] opc, mag;
  logic signed [31:0] csw;
  assign csw = a_tag[31:0];
  assign opc = 32'(ONE_Q30) + csw;
  assign mag = csw[31] ? -csw : csw;
  always_ff @(posedge clk) begin
    if (!rst_n) n_v_r <= 1'b0;
    else n_v_r <= a_v;
    den_r <= 39'(ONE_Q30) + 39'(a_quo);
    n_ff0_r <= {1'b0, opc, 29'd0};
    n_ff1_r <= {opc, 30'd0};
    n_fb1_r <= {mag[30:0], 31'd0};
    n_fb2_r <= {1'b1, 61'd0};
    n_tag_r <= {a_tag[32], csw[31]};
  end

  logic d_v [4];
  logic [61:0] d_q [4];
  logic [1:0] d_t [4];
  logic [61:0] nums [4];
  assign nums[0] = n_ff0_r;
  assign nums[1] = n_ff1_r;
  assign nums[2] = n_fb1_r;
  assign nums[3] = n_fb2_r;
  for (genvar k = 0; k < 4; k++) begin : g_div
    bhpc_divider #(.NUM_W(62), .DEN_W(39), .TAG_W(2)) u_div (
      .clk(clk), .rst_n(rst_n), .vld_i(n_v_r), .num_i(nums[k]), .den_i(den_r),
      .tag_i(n_tag_r), .vld_o(d_v[k]), .quo_o(d_q[k]), .tag_o(d_t[k])
    );
  end

  // Sign, scale to COEF_WIDTH and saturate.
  localparam int SH = COEF_WIDTH - 32;
  function automatic logic [31:0] fin(input logic signed [63:0] v);
    logic signed [63:0] t, hi, lo;
    if (SH < 0) t = (v + (64'sd1 <<< (-SH - 1))) >>> (-SH);
    else t = v <<< SH;
    hi = (64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (t > hi) t = hi;
    if (t < lo) t = lo;
    return t[31:0];
  endfunction

  logic o_v_r, bad_r;
  logic [31:0] ff0_r, ff1_r, fb1_r, fb2_r;
  logic signed [63:0] v0, v1, v3, v4;
  assign v0 = $signed({2'b00, d_q[0]});
  assign v1 = -$signed({2'b00, d_q[1]});
  assign v3 = d_t[2][0] ? -$signed({2'b00, d_q[2]}) : $signed({2'b00, d_q[2]});
  assign v4 = 64'(ONE_Q30) - $signed({2'b00, d_q[3]});
  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else o_v_r <= d_v[0];
    bad_r <= d_t[0][1];
    ff0_r <= d_t[0][1] ? '0 : fin(v0);
    ff1_r <= d_t[0][1] ? '0 : fin(v1);
    fb1_r <= d_t[0][1] ? '0 : fin(v3);
    fb2_r <= d_t[0][1] ? '0 : fin(v4);
  end

  assign out_valid = o_v_r;
  assign out_ff0 = ff0_r;
  assign out_ff1 = ff1_r;
  assign out_ff2 = ff0_r;
  assign out_fb1 = fb1_r;
  assign out_fb2 = fb2_r;
  assign out_bad_q = bad_r & o_v_r;

  `ASSERT_IMP(a_never_busy, 1'b1, !busy)
  `ASSERT_IMP(a_bad_zero, out_valid && out_bad_q, out_ff0 == 0 && out_fb2 == 0)
  `ASSERT_IMP(a_lanes_align, d_v[0], d_v[1] && d_v[2] && d_v[3])
  `ASSERT_NXT(a_out_follows, d_v[0], out_valid)
endmodule
